@@ rtl/pecsc_pkg.sv @@
package pecsc_pkg;

  localparam int TableDepth = 16;
  localparam int TagBits    = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_ECHO = 2'd1,
    ACT_DROP = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SKIPPED  = 3'd1,
    ST_TOO_MANY = 3'd2,
    ST_ROLLBACK = 3'd3,
    ST_FAST     = 3'd4,
    ST_NO_MATCH = 3'd5,
    ST_DROP_BAD = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_SESSION  = 3'd0,
    REG_SEND_GAP = 3'd1,
    REG_MAX_OUT  = 3'd2,
    REG_SKEW     = 3'd3,
    REG_ROLLBACK = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [31:0] ping_word;
    logic [63:0] ping_tag;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        lag_flag;
    logic [30:0] latency_ms;
  } out_beat_t;

  // Table port: read one entry, shift entries down, append at the tail.
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_idx;
    logic            shift_en;
    logic [IdxW-1:0] shift_idx;
    logic            push;
  } tbl_ctl_t;

endpackage

@@ rtl/pecsc_table.sv @@
module pecsc_table
  import pecsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tbl_ctl_t            ctl,
  input  logic [31:0]         push_word,
  input  logic [TagBits-1:0]  push_tag,
  input  logic [31:0]         push_time,
  output logic [31:0]         rd_word,
  output logic [TagBits-1:0]  rd_tag,
  output logic [31:0]         rd_time,
  output logic [CntW-1:0]     fill
);

  logic [31:0]        word_mem [TableDepth];
  logic [TagBits-1:0] tag_mem  [TableDepth];
  logic [31:0]        time_mem [TableDepth];

  // Fill count: valid entries are packed at the low end.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.push) begin
      fill <= fill + CntW'(1);
    end else if (ctl.shift_en && ctl.shift_idx == IdxW'(fill - CntW'(1))) begin
      fill <= fill - CntW'(1);
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_word <= word_mem[ctl.rd_idx];
      rd_tag  <= tag_mem[ctl.rd_idx];
      rd_time <= time_mem[ctl.rd_idx];
    end
  end

  // Single write port: append or move one entry down a slot per cycle.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word_mem[IdxW'(fill)] <= push_word;
      tag_mem[IdxW'(fill)]  <= push_tag;
      time_mem[IdxW'(fill)] <= push_time;
    end else if (ctl.shift_en && ctl.shift_idx != IdxW'(fill - CntW'(1))) begin
      word_mem[ctl.shift_idx] <= rd_word;
      tag_mem[ctl.shift_idx]  <= rd_tag;
      time_mem[ctl.shift_idx] <= rd_time;
    end
  end

endmodule

@@ rtl/ping_echo_clock_skew_checker.sv @@
// Ping/echo clock skew checker. One beat is taken at a time; in_stall is high
// from the accepting edge until the result beat has left the output register.
// A send, a drop or an unused action goes through S_CHECK and S_DONE. An echo
// reads the ping table one entry at a time through its single registered read
// port, reading each entry in S_SCAN and doing its tag and skew compare in
// S_CHECK. The removal of a match then moves the later entries down one slot
// per cycle in S_SHIFT. A result beat still held by out_stall when the
// sequence ends delays the next beat.
module ping_echo_clock_skew_checker
  import pecsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        session_bound;
  logic [15:0] send_gap_ms;
  logic [4:0]  max_outstanding;
  logic [15:0] skew_limit_ms;
  logic [7:0]  rollback_tolerance_ms;

  state_t state, state_next;
  in_beat_t item;
  logic [IdxW:0] idx, idx_next;
  logic [4:0]  sent_count;
  logic [31:0] last_send_time, base_server_time, base_client_time;
  logic [31:0] prev_client_time, prev_word, prev_latency;
  logic [TagBits-1:0] prev_tag;
  logic        base_valid;
  logic        accept;

  tbl_ctl_t ctl;
  logic [31:0] rd_word, rd_time;
  logic [TagBits-1:0] rd_tag;
  logic [CntW-1:0] fill;

  pecsc_table u_table (
    .clk, .rst, .ctl,
    .push_word(item.ping_word), .push_tag(item.ping_tag[TagBits-1:0]),
    .push_time(item.now_ms),
    .rd_word, .rd_tag, .rd_time, .fill
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      session_bound         <= 1'b0;
      send_gap_ms           <= 16'd5000;
      max_outstanding       <= 5'd15;
      skew_limit_ms         <= 16'd5000;
      rollback_tolerance_ms <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SESSION:  session_bound         <= cfg_data[0];
        REG_SEND_GAP: send_gap_ms           <= cfg_data;
        REG_MAX_OUT:  max_outstanding       <= cfg_data[4:0];
        REG_SKEW:     skew_limit_ms         <= cfg_data;
        REG_ROLLBACK: rollback_tolerance_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Shared echo arithmetic on the entry that was read.
  logic [31:0] client, rtt, half;
  logic signed [31:0] step, sgap, cgap;
  logic signed [32:0] c_minus_s, s_minus_c;
  logic tag_hit, rollback, fast, lag;
  always_comb begin
    client    = item.ping_word ^ rd_word;
    rtt       = item.now_ms - rd_time;
    half      = {1'b0, rtt[31:1]};
    step      = client - prev_client_time;
    sgap      = item.now_ms - base_server_time;
    cgap      = client - base_client_time;
    c_minus_s = 33'(cgap) - 33'(sgap);
    s_minus_c = 33'(sgap) - 33'(cgap);
    tag_hit   = (rd_tag == item.ping_tag[TagBits-1:0]);
    rollback  = 33'(step) < -$signed({25'd0, rollback_tolerance_ms});
    fast      = cgap < 0 || c_minus_s > $signed({17'd0, skew_limit_ms});
    lag       = s_minus_c > $signed({17'd0, skew_limit_ms});
  end

  // Hole tracking for the shift: the first shift cycle must not write.
  logic first_shift;

  // Sequencer.
  logic    idx_end;
  status_t res_status;
  logic    res_lag, res_load;
  logic [30:0] res_lat;
  logic [31:0] since;
  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl        = '0;
    res_load   = 1'b0;
    res_status = ST_OK;
    res_lag    = 1'b0;
    res_lat    = '0;
    since      = item.now_ms - last_send_time;
    idx_end    = (idx >= (IdxW+1)'(fill));
    ctl.rd_idx = idx[IdxW-1:0];
    ctl.shift_idx = IdxW'(idx - (IdxW+1)'(2));
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_data.action == ACT_ECHO) ? S_SCAN : S_CHECK;
          idx_next   = '0;
        end
      end
      S_SCAN: begin
        // Read entry idx; the result is checked in S_CHECK.
        if (idx_end) begin
          res_load = 1'b1; res_status = ST_NO_MATCH; state_next = S_DONE;
        end else begin
          ctl.rd_en = 1'b1; idx_next = idx + (IdxW+1)'(1); state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (item.action)
          ACT_SEND: begin
            res_load = 1'b1; state_next = S_DONE;
            if (sent_count >= max_outstanding || fill == CntW'(TableDepth))
              res_status = ST_TOO_MANY;
            else if (since < 32'(send_gap_ms))
              res_status = ST_SKIPPED;
            else if (session_bound)
              ctl.push = 1'b1;
          end
          ACT_DROP: begin
            res_load = 1'b1; state_next = S_DONE;
            if ((prev_word != '0 || prev_tag != '0) && prev_word == item.ping_word &&
                prev_tag == item.ping_tag[TagBits-1:0])
              res_lat = prev_latency[30:0];
            else
              res_status = ST_DROP_BAD;
          end
          ACT_ECHO: begin
            if (!tag_hit) begin
              state_next = S_SCAN;
            end else begin
              res_load = 1'b1;
              if (base_valid && rollback)      res_status = ST_ROLLBACK;
              else if (base_valid && fast)     res_status = ST_FAST;
              else                             res_lag = base_valid && lag;
              // Remove the matched entry by moving later ones down.
              state_next = S_SHIFT;
            end
          end
          default: begin
            res_load = 1'b1; state_next = S_DONE;
          end
        endcase
      end
      S_SHIFT: begin
        // idx points past the entry last read; write that entry one slot
        // lower, then drop the tail slot once every later entry has moved.
        if (idx > (IdxW+1)'(fill)) begin
          ctl.shift_en = 1'b1; state_next = S_DONE;
        end else begin
          ctl.rd_en    = !idx_end;
          ctl.shift_en = !first_shift;
          idx_next     = idx + (IdxW+1)'(1);
        end
      end
      S_DONE: begin
        if (!out_valid) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) first_shift <= 1'b0;
    else     first_shift <= (state == S_CHECK && state_next == S_SHIFT);
  end

  // Registers of the sequencer and the session state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      idx              <= '0;
      out_valid        <= 1'b0;
      sent_count       <= '0;
      last_send_time   <= '0;
      base_valid       <= 1'b0;
      base_server_time <= '0;
      base_client_time <= '0;
      prev_client_time <= '0;
      prev_word        <= '0;
      prev_tag         <= '0;
      prev_latency     <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (res_load) begin
        out_valid           <= 1'b1;
        out_data.status     <= res_status;
        out_data.lag_flag   <= res_lag;
        out_data.latency_ms <= res_lat;
      end
      if (ctl.push) begin
        if (sent_count < 5'd31) sent_count <= sent_count + 5'd1;
        last_send_time <= item.now_ms;
      end
      if (state == S_CHECK && item.action == ACT_DROP && res_status == ST_OK) begin
        prev_word <= '0;
        prev_tag  <= '0;
      end
      if (state == S_CHECK && item.action == ACT_ECHO && tag_hit &&
          res_status == ST_OK) begin
        if (!base_valid) begin
          base_valid       <= 1'b1;
          base_server_time <= rd_time;
          base_client_time <= client - half;
        end
        prev_word        <= rd_word;
        prev_tag         <= rd_tag;
        prev_client_time <= client;
        prev_latency     <= half;
        if (sent_count != '0) sent_count <= sent_count - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= in_data;
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !accept;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("beat taken while busy");

  property p_fill_bound;
    @(posedge clk) disable iff (rst) fill <= CntW'(TableDepth);
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("table overfilled");

  property p_push_not_full;
    @(posedge clk) disable iff (rst) ctl.push |-> fill != CntW'(TableDepth);
  endproperty
  a_push_not_full: assert property (p_push_not_full) else $error("push into full table");

endmodule
